// ===== rtl/core/vlrc_pkg.sv =====
// ----------------------------------------------------------------------------
// vlrc_pkg: shared types and constants of the neighbor-list rebuild check
// Field widths, command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vlrc_pkg;

	// Number of displacement components that enter the length (2 or 3)
	localparam int DIMS = 3;
	localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;

	// Field widths
	localparam int COMP_W = 24;              // signed displacement component
	localparam int MAG_W = COMP_W + 1;       // |now - prev|, unsigned
	localparam int SUM_W = 2 * MAG_W;        // sum of squares
	localparam int MOVE_W = MAG_W;           // square root of the sum
	localparam int SKIN_W = 24;
	localparam int CNT_W = 16;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;

	// Square root: two radicand bits per step
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
	localparam int REM_W = MOVE_W + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SKIN_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVERY_STEPS = 2'd1;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Controller to datapath
	typedef struct packed {
		logic             capture;     // latch request, form component magnitudes
		logic             mul;         // square one component
		logic             acc;         // add the square into the sum
		logic [DIM_W-1:0] dim;         // component being squared
		logic             root_start;  // launch the square root
		logic             update;      // top-two update and threshold compare
		logic             emit;        // load the result register, end the step
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic measure;    // displacement criterion active and not yet decided
		logic last;       // current request closes the time step
		logic root_done;  // square root finished this cycle
		logic out_free;   // result register can take a new result
	} stat_t;

endpackage

// ===== rtl/core/verlet_list_rebuild_check_top.sv =====
// ----------------------------------------------------------------------------
// verlet_list_rebuild_check_top: neighbor-list skin rebuild criterion
// Tracks the two largest particle moves of a time step and decides whether
// the neighbor list has to be rebuilt, or rebuilds on a fixed period.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one request per particle, carrying
//    its current and stored displacement; last_of_step marks the final one.
//  - Output channel (out_valid / out_stall): one result per time step, given
//    after the request marked last_of_step.
//  - Config port (cfg_we, cfg_index, cfg_data): skin_size at index 0,
//    every_steps at index 1; write only while the block is idle.
//  - Timing: a measured request runs through the shared squarer, one
//    component after another, and then the
//    two-bit-per-cycle square root of the 50-bit sum of squares. In period
//    mode, or once the step is decided, a request skips both; the last
//    request of a step also loads the result. One request is in work at a time.
//  - The result sits in an output register; the block goes on taking
//    requests while it waits, and holds off only when a new result is due.
//  - Reset clears the config registers, the tracked moves, the decision and
//    the step counter; no result is pending after reset.
// ----------------------------------------------------------------------------
module verlet_list_rebuild_check_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vlrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vlrc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_x,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_y,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_z,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_x,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_y,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_z,
	input  logic                              last_of_step,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              rebuild,
	output logic [vlrc_pkg::CNT_W-1:0]        steps_since_rebuild,
	output logic [vlrc_pkg::MOVE_W-1:0]       largest_move,
	output logic [vlrc_pkg::MOVE_W-1:0]       second_move
);
	import vlrc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	vlrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Registers and arithmetic
	vlrc_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.disp_now_x          (disp_now_x),
		.disp_now_y          (disp_now_y),
		.disp_now_z          (disp_now_z),
		.disp_prev_x         (disp_prev_x),
		.disp_prev_y         (disp_prev_y),
		.disp_prev_z         (disp_prev_z),
		.last_of_step        (last_of_step),
		.cmd                 (cmd),
		.stat                (stat),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.rebuild             (rebuild),
		.steps_since_rebuild (steps_since_rebuild),
		.largest_move        (largest_move),
		.second_move         (second_move)
	);

endmodule

// ===== rtl/core/vlrc_isqrt.sv =====
// ----------------------------------------------------------------------------
// vlrc_isqrt: iterative integer square root
// Restoring digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vlrc_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [vlrc_pkg::SUM_W-1:0] radicand,
	output logic                      done,
	output logic [vlrc_pkg::MOVE_W-1:0] root
);
	import vlrc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [MOVE_W-1:0]     root_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             fits;

	// One digit: bring down two bits, try (4*root + 1)
	always_comb begin
		rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ROOT_CNT_W'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SUM_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[MOVE_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[MOVE_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/core/vlrc_datapath.sv =====
// ----------------------------------------------------------------------------
// vlrc_datapath: registers and arithmetic of the rebuild check
// Config registers, component magnitudes, shared multiplier, sum of squares,
// square root, top-two tracking, step counter and result register.
// ----------------------------------------------------------------------------
module vlrc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vlrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vlrc_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_x,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_y,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_now_z,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_x,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_y,
	input  logic signed [vlrc_pkg::COMP_W-1:0] disp_prev_z,
	input  logic                              last_of_step,
	input  vlrc_pkg::cmd_t                    cmd,
	output vlrc_pkg::stat_t                   stat,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              rebuild,
	output logic [vlrc_pkg::CNT_W-1:0]        steps_since_rebuild,
	output logic [vlrc_pkg::MOVE_W-1:0]       largest_move,
	output logic [vlrc_pkg::MOVE_W-1:0]       second_move
);
	import vlrc_pkg::*;

	// Configuration
	logic [SKIN_W-1:0] skin_q;
	logic [CNT_W-1:0]  every_q;

	// Per-request state
	logic [MAG_W-1:0] mag_q [DIMS];
	logic             last_q;
	logic [SUM_W-1:0] prod_s1;
	logic [SUM_W-1:0] sum_q;

	// Per-step state
	logic [MOVE_W-1:0] top_q;
	logic [MOVE_W-1:0] runner_q;
	logic              decided_q;
	logic [CNT_W-1:0]  cnt_q;

	// Result register
	logic              out_valid_q;
	logic              rebuild_q;
	logic [CNT_W-1:0]  steps_q;
	logic [MOVE_W-1:0] largest_q;
	logic [MOVE_W-1:0] second_q;

	logic signed [COMP_W-1:0] now_a  [3];
	logic signed [COMP_W-1:0] prev_a [3];
	logic signed [MAG_W-1:0]  diff_a [DIMS];
	logic [MAG_W-1:0]         abs_a  [DIMS];

	logic              root_done;
	logic [MOVE_W-1:0] root;

	logic [MOVE_W-1:0] top_n;
	logic [MOVE_W-1:0] runner_n;
	logic [MOVE_W:0]   pair_sum;

	logic              period_mode;
	logic              rebuild_n;
	logic [CNT_W-1:0]  cnt_n;

	// Config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_q  <= '0;
			every_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SKIN_SIZE:   skin_q  <= cfg_data[SKIN_W-1:0];
				REG_EVERY_STEPS: every_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Component magnitudes |now - prev|
	always_comb begin
		now_a[0]  = disp_now_x;
		now_a[1]  = disp_now_y;
		now_a[2]  = disp_now_z;
		prev_a[0] = disp_prev_x;
		prev_a[1] = disp_prev_y;
		prev_a[2] = disp_prev_z;
		for (int d = 0; d < DIMS; d++) begin
			diff_a[d] = MAG_W'(now_a[d]) - MAG_W'(prev_a[d]);
			abs_a[d]  = diff_a[d][MAG_W-1] ? MAG_W'(-diff_a[d]) : MAG_W'(diff_a[d]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int d = 0; d < DIMS; d++) begin
				mag_q[d] <= abs_a[d];
			end
			last_q <= last_of_step;
		end
	end

	// Shared squarer, then accumulate
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= mag_q[cmd.dim] * mag_q[cmd.dim];
		end
		if (cmd.capture) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + prod_s1;
		end
	end

	vlrc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	// Top-two update; old maximum drops to second place
	always_comb begin
		if (root > top_q) begin
			top_n    = root;
			runner_n = top_q;
		end else if (root > runner_q) begin
			top_n    = top_q;
			runner_n = root;
		end else begin
			top_n    = top_q;
			runner_n = runner_q;
		end
		pair_sum = {1'b0, top_n} + {1'b0, runner_n};
	end

	// End-of-step decision and counter
	always_comb begin
		period_mode = (every_q != '0);
		if (period_mode) begin
			rebuild_n = (cnt_q == '0) || (cnt_q == every_q);
		end else begin
			rebuild_n = decided_q;
		end
		if (rebuild_n) begin
			cnt_n = CNT_W'(1);
		end else if (cnt_q != CNT_MAX) begin
			cnt_n = cnt_q + 1'b1;
		end else begin
			cnt_n = cnt_q;
		end
	end

	// Step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			runner_q  <= '0;
			decided_q <= 1'b0;
			cnt_q     <= '0;
		end else if (cmd.emit) begin
			top_q     <= '0;
			runner_q  <= '0;
			decided_q <= 1'b0;
			cnt_q     <= cnt_n;
		end else if (cmd.update) begin
			top_q    <= top_n;
			runner_q <= runner_n;
			if (pair_sum >= (MOVE_W+1)'(skin_q)) begin
				decided_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rebuild_q <= rebuild_n;
			steps_q   <= cnt_n;
			largest_q <= top_q;
			second_q  <= runner_q;
		end
	end

	// Status to controller
	always_comb begin
		stat.measure   = !period_mode && !decided_q;
		stat.last      = last_q;
		stat.root_done = root_done;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid           = out_valid_q;
	assign rebuild             = rebuild_q;
	assign steps_since_rebuild = steps_q;
	assign largest_move        = largest_q;
	assign second_move         = second_q;

	// Checks
	a_top_order: assert property (@(posedge clk) disable iff (!arst_n)
		runner_q <= top_q)
		else $error("second largest move exceeds largest move");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an unaccepted result");

	a_root_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_start |=> !root_done)
		else $error("square root finished too early");

endmodule

// ===== rtl/core/vlrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlrc_ctrl: sequencer of the rebuild check
// Accepts one request; if measured, steps the squarer over the components,
// runs the square root, updates the top-two tracking; emits at step end.
// ----------------------------------------------------------------------------
module vlrc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  vlrc_pkg::stat_t stat,
	output vlrc_pkg::cmd_t  cmd
);
	import vlrc_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_CHECK     = 3'd1;
	localparam logic [2:0] ST_MUL       = 3'd2;
	localparam logic [2:0] ST_ACC       = 3'd3;
	localparam logic [2:0] ST_ROOT_GO   = 3'd4;
	localparam logic [2:0] ST_ROOT_WAIT = 3'd5;
	localparam logic [2:0] ST_UPDATE    = 3'd6;
	localparam logic [2:0] ST_EMIT      = 3'd7;

	localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(DIMS - 1);

	logic [2:0]       state_q;
	logic [2:0]       state_n;
	logic [DIM_W-1:0] dim_q;

	// Next state and commands
	always_comb begin
		state_n        = state_q;
		cmd            = '0;
		cmd.dim        = dim_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.measure) begin
					state_n = ST_MUL;
				end else if (stat.last) begin
					state_n = ST_EMIT;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (dim_q == DIM_LAST) begin
					state_n = ST_ROOT_GO;
				end else begin
					state_n = ST_MUL;
				end
			end
			ST_ROOT_GO: begin
				cmd.root_start = 1'b1;
				state_n        = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (stat.root_done) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (stat.last) begin
					state_n = ST_EMIT;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State and component counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CHECK) begin
				dim_q <= '0;
			end else if (state_q == ST_ACC && dim_q != DIM_LAST) begin
				dim_q <= dim_q + 1'b1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Checks
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after a result");

	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.root_done |-> state_q == ST_ROOT_WAIT)
		else $error("square root result arrived outside its wait state");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		dim_q <= DIM_LAST)
		else $error("component counter out of range");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the neighbor-list rebuild check
// Drives particle requests with random gaps, predicts each step's verdict
// (largest two moves, skin threshold, fixed period, step counter) and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import vlrc_pkg::*;

	localparam int COMP_HI = 8388607;
	localparam int COMP_LO = -8388608;
	localparam int IDLE_WAIT = 60;      // longer than one measured request
	localparam int LONG_HOLD = 400;
	localparam int WATCH_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_REQS = 42;
	localparam int PAST_STEPS = 12;

	// Index values the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [COMP_W-1:0] now_x;
		logic [COMP_W-1:0] now_y;
		logic [COMP_W-1:0] now_z;
		logic [COMP_W-1:0] prev_x;
		logic [COMP_W-1:0] prev_y;
		logic [COMP_W-1:0] prev_z;
		logic              last;
	} particle_req_t;

	typedef struct packed {
		logic              rebuild;
		logic [CNT_W-1:0]  steps;
		logic [MOVE_W-1:0] largest;
		logic [MOVE_W-1:0] second;
	} move_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COMP_W-1:0] disp_now_x = '0;
	logic signed [COMP_W-1:0] disp_now_y = '0;
	logic signed [COMP_W-1:0] disp_now_z = '0;
	logic signed [COMP_W-1:0] disp_prev_x = '0;
	logic signed [COMP_W-1:0] disp_prev_y = '0;
	logic signed [COMP_W-1:0] disp_prev_z = '0;
	logic last_of_step = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic rebuild;
	logic [CNT_W-1:0] steps_since_rebuild;
	logic [MOVE_W-1:0] largest_move;
	logic [MOVE_W-1:0] second_move;

	// Predictor state and its copy of the registers
	logic [SKIN_W-1:0] cfg_skin = '0;
	logic [CNT_W-1:0] cfg_period = '0;
	logic [MOVE_W-1:0] trk_top = '0;
	logic [MOVE_W-1:0] trk_second = '0;
	logic trk_decided = 1'b0;
	logic [CNT_W-1:0] trk_steps = '0;

	particle_req_t pending_reqs[$];
	move_verdict_t verdicts_due[$];
	particle_req_t cur_req;
	int n_pushed = 0;
	int n_offered = 0;
	int n_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_hold = 0;
	int rx_calm = 0;
	int long_asks = 0;
	int long_served = 0;
	bit quick = 1'b0;

	verlet_list_rebuild_check_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.disp_now_x          (disp_now_x),
		.disp_now_y          (disp_now_y),
		.disp_now_z          (disp_now_z),
		.disp_prev_x         (disp_prev_x),
		.disp_prev_y         (disp_prev_y),
		.disp_prev_z         (disp_prev_z),
		.last_of_step        (last_of_step),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.rebuild             (rebuild),
		.steps_since_rebuild (steps_since_rebuild),
		.largest_move        (largest_move),
		.second_move         (second_move)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Floor of the square root, one result bit per trial
	function automatic logic [MOVE_W-1:0] floor_root(input longint radicand);
		longint root;
		longint trial;
		root = 0;
		for (int b = MOVE_W - 1; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root[MOVE_W-1:0];
	endfunction

	// Euclidean length of (now - prev)
	function automatic logic [MOVE_W-1:0] move_length(input particle_req_t r);
		longint dx, dy, dz, radicand;
		dx = longint'($signed(r.now_x)) - longint'($signed(r.prev_x));
		dy = longint'($signed(r.now_y)) - longint'($signed(r.prev_y));
		dz = longint'($signed(r.now_z)) - longint'($signed(r.prev_z));
		radicand = dx * dx + dy * dy;
		if (DIMS > 2)
			radicand += dz * dz;
		return floor_root(radicand);
	endfunction

	// Step tracking for one accepted request; queues a verdict at end of step
	function automatic void predict_request(input particle_req_t r);
		logic [MOVE_W-1:0] len;
		logic [MOVE_W:0] pair_sum;
		logic fire;
		if (cfg_period == '0 && !trk_decided) begin
			len = move_length(r);
			if (len > trk_top) begin
				trk_second = trk_top;
				trk_top = len;
			end else if (len > trk_second) begin
				trk_second = len;
			end
			pair_sum = trk_top + trk_second;
			if (pair_sum >= cfg_skin)
				trk_decided = 1'b1;
		end
		if (!r.last)
			return;
		if (cfg_period != '0)
			fire = (trk_steps == '0) || (trk_steps == cfg_period);
		else
			fire = trk_decided;
		if (fire)
			trk_steps = CNT_W'(1);
		else if (trk_steps != CNT_MAX)
			trk_steps = trk_steps + 1'b1;
		verdicts_due.push_back('{rebuild: fire, steps: trk_steps,
			largest: trk_top, second: trk_second});
		trk_top = '0;
		trk_second = '0;
		trk_decided = 1'b0;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		move_verdict_t want;
		if (verdicts_due.size() == 0) begin
			$error("result with no step pending");
			mismatches++;
			return;
		end
		want = verdicts_due.pop_front();
		compare_field("rebuild", 32'(want.rebuild), 32'(rebuild));
		compare_field("steps_since_rebuild", 32'(want.steps), 32'(steps_since_rebuild));
		compare_field("largest_move", 32'(want.largest), 32'(largest_move));
		compare_field("second_move", 32'(want.second), 32'(second_move));
	endtask

	// Rising edge: register writes, accepted requests and results
	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				REG_SKIN_SIZE: cfg_skin = cfg_data[SKIN_W-1:0];
				REG_EVERY_STEPS: cfg_period = cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
		if (out_valid && !out_stall)
			check_result();
		if (in_valid && !in_stall) begin
			predict_request(cur_req);
			n_taken++;
		end
	end

	// Watchdog: too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Sender gap after a request: mostly none, sometimes long, calm stretches
	function automatic int sender_gap();
		int roll;
		if (quick)
			return 0;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			tx_calm = $urandom_range(15, 60);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Request driver
	always @(negedge clk) begin
		if (in_valid && n_taken != n_offered) begin
			// held until the block takes it
		end else if (tx_gap > 0) begin
			in_valid <= 1'b0;
			tx_gap--;
		end else if (pending_reqs.size() != 0) begin
			cur_req = pending_reqs.pop_front();
			disp_now_x <= cur_req.now_x;
			disp_now_y <= cur_req.now_y;
			disp_now_z <= cur_req.now_z;
			disp_prev_x <= cur_req.prev_x;
			disp_prev_y <= cur_req.prev_y;
			disp_prev_z <= cur_req.prev_z;
			last_of_step <= cur_req.last;
			in_valid <= 1'b1;
			n_offered++;
			tx_gap = sender_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result side stall pattern
	always @(negedge clk) begin
		int roll;
		if (long_asks != long_served) begin
			long_served++;
			rx_hold = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= 1'b0;
			if (!quick) begin
				if (rx_calm > 0) begin
					rx_calm--;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						rx_calm = $urandom_range(20, 80);
					else if (roll < 20)
						rx_hold = $urandom_range(1, 3);
					else if (roll < 27)
						rx_hold = $urandom_range(4, 15);
					else if (roll < 29)
						rx_hold = $urandom_range(30, 120);
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for all requests and results, then let a request without result drain
	task automatic settle();
		while (n_taken != n_pushed || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic push_particle(input int nx, input int ny, input int nz,
			input int px, input int py, input int pz, input bit last);
		particle_req_t r;
		r.now_x = nx[COMP_W-1:0];
		r.now_y = ny[COMP_W-1:0];
		r.now_z = nz[COMP_W-1:0];
		r.prev_x = px[COMP_W-1:0];
		r.prev_y = py[COMP_W-1:0];
		r.prev_z = pz[COMP_W-1:0];
		r.last = last;
		pending_reqs.push_back(r);
		n_pushed++;
	endtask

	// Random particle: mostly a move bounded by 2^bits, else unrelated or still
	task automatic push_random(input int bits, input bit last);
		int roll, d;
		int nv[3];
		int pv[3];
		roll = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			nv[k] = $urandom_range(0, 16777215) + COMP_LO;
			if (roll < 12) begin
				pv[k] = $urandom_range(0, 16777215) + COMP_LO;
			end else if (roll < 20) begin
				pv[k] = nv[k];
			end else begin
				d = $urandom_range(0, (1 << bits) - 1);
				if ($urandom_range(0, 1))
					d = -d;
				if (nv[k] - d > COMP_HI || nv[k] - d < COMP_LO)
					d = -d;
				pv[k] = nv[k] - d;
			end
		end
		push_particle(nv[0], nv[1], nv[2], pv[0], pv[1], pv[2], last);
	endtask

	task automatic push_step();
		int roll, n, bits;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			n = $urandom_range(1, 4);
		else if (roll < 95)
			n = $urandom_range(5, 10);
		else
			n = $urandom_range(11, 20);
		bits = $urandom_range(4, 23);
		for (int i = 0; i < n; i++)
			push_random(bits, i == n - 1);
	endtask

	initial begin
		int r, start;
		logic [SKIN_W-1:0] skin;
		logic [CNT_W-1:0] period;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Zero skin out of reset: the first measured particle decides
		push_particle(5, 5, 5, 5, 5, 5, 1'b1);
		settle();
		write_reg(REG_SKIN_SIZE, '1);
		write_reg(REG_EVERY_STEPS, '0);
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '1);

		// Extreme vectors decide at once; the later particle is not measured
		push_particle(COMP_HI, COMP_HI, COMP_HI, COMP_LO, COMP_LO, COMP_LO, 1'b0);
		push_particle(COMP_LO, COMP_LO, COMP_LO, COMP_HI, COMP_HI, COMP_HI, 1'b1);
		// New maximum demotes the old one; one component per particle
		push_particle(1000, 0, 0, 0, 0, 0, 1'b0);
		push_particle(0, 5000, 0, 0, 0, 0, 1'b0);
		push_particle(0, 0, 0, 0, 0, 3000, 1'b1);
		// Sum of the two moves lands exactly on the skin
		push_particle(COMP_HI, 0, 0, 0, 0, 0, 1'b0);
		push_particle(0, 0, 0, COMP_LO, 0, 0, 1'b1);
		// Step opened in displacement mode, closed in period mode
		push_particle(200, 0, 0, 0, 0, 0, 1'b0);
		settle();
		write_reg(REG_EVERY_STEPS, 24'hFF0001);
		repeat (3) push_random(23, 1'b1);
		settle();
		write_reg(REG_EVERY_STEPS, CFG_W'(3));
		repeat (3) push_random(23, 1'b1);
		push_random(23, 1'b0);
		push_random(23, 1'b0);
		push_random(23, 1'b1);
		push_random(23, 1'b1);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			// Counter runs past a lowered period, then meets the top period
			if (ph == 6) begin
				write_reg(REG_SKIN_SIZE, '1);
				write_reg(REG_EVERY_STEPS, '0);
				repeat (3) push_particle(0, 0, 0, 0, 0, 0, 1'b1);
				settle();
				write_reg(REG_EVERY_STEPS, CFG_W'(2));
				quick = 1'b1;
				repeat (PAST_STEPS) push_random(8, 1'b1);
				settle();
				quick = 1'b0;
				write_reg(REG_EVERY_STEPS, CFG_W'(CNT_MAX));
				push_random(8, 1'b1);
				settle();
			end

			r = $urandom_range(0, 9);
			if (r == 0)
				skin = '0;
			else if (r == 1)
				skin = '1;
			else if (r < 5)
				skin = SKIN_W'($urandom());
			else
				skin = SKIN_W'($urandom_range(0, (1 << $urandom_range(10, 20)) - 1));
			r = $urandom_range(0, 9);
			if (r < 6)
				period = '0;
			else if (r == 6)
				period = CNT_W'(1);
			else if (r == 7)
				period = CNT_MAX;
			else
				period = CNT_W'($urandom_range(2, 6));
			if (ph == 2)
				period = CNT_W'(1);
			write_reg(REG_SKIN_SIZE, skin);
			write_reg(REG_EVERY_STEPS, {8'($urandom()), period});
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_W'($urandom()));

			start = n_pushed;
			if (ph == 2) begin
				// Long result stall while short steps keep coming
				long_asks++;
				repeat (PHASE_REQS) push_random(23, 1'b1);
			end else begin
				while (n_pushed - start < PHASE_REQS)
					push_step();
				if ($urandom_range(0, 2) == 0)
					push_random($urandom_range(4, 23), 1'b0);
			end
			settle();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
